[rtl/sdc_pkg.sv]
// shared constants and types for the spectrum decimation and colormap block
package sdc_pkg;

  localparam int unsigned MAX_BINS_DEF = 8192;

  // divider operand and counter widths
  localparam int unsigned DIV_DVD_W = 36;
  localparam int unsigned DIV_DVS_W = 20;
  localparam int unsigned DIV_CNT_W = 6;

  // amplitudes in 1/16 dB
  localparam logic signed [12:0] PEAK_INIT  = -13'sd3200;
  localparam logic signed [12:0] PEAK_FLOOR = -13'sd3184;
  localparam logic signed [12:0] PEAK_SUBST = -13'sd1920;

  // register reset values
  localparam logic [13:0]        BIN_COUNT_RST   = 14'd512;
  localparam logic [2:0]         LOD_LEVEL_RST   = 3'd0;
  localparam logic [11:0]        FREQ_SCALE_RST  = 12'd256;
  localparam logic signed [12:0] COLOR_LOWER_RST = -13'sd2560;
  localparam logic signed [12:0] COLOR_UPPER_RST = -13'sd1280;
  localparam logic signed [12:0] PAN_MIN_RST     = -13'sd2240;
  localparam logic signed [12:0] PAN_MAX_RST     = -13'sd640;

  // register indexes
  localparam logic [2:0] REG_BIN_COUNT   = 3'd0;
  localparam logic [2:0] REG_LOD_LEVEL   = 3'd1;
  localparam logic [2:0] REG_FREQ_SCALE  = 3'd2;
  localparam logic [2:0] REG_COLOR_LOWER = 3'd3;
  localparam logic [2:0] REG_COLOR_UPPER = 3'd4;
  localparam logic [2:0] REG_PAN_MIN     = 3'd5;
  localparam logic [2:0] REG_PAN_MAX     = 3'd6;

  typedef struct packed {
    logic                 start;
    logic [DIV_DVD_W-1:0] dividend;
    logic [DIV_DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_DVD_W-1:0] quotient;
    logic [DIV_DVS_W-1:0] remainder;
  } div_rsp_t;

endpackage

[rtl/sdc_div.sv]
// shared unsigned restoring divider, one quotient bit per cycle
module sdc_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sdc_pkg::div_req_t req_i,
  output sdc_pkg::div_rsp_t rsp_o
);
  import sdc_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_DVD_W-1:0] quo_q;
  logic [DIV_DVS_W-1:0] rem_q;
  logic [DIV_DVS_W-1:0] dvs_q;
  logic [DIV_DVS_W:0]   trial;
  logic                 ge;

  assign trial = {rem_q, quo_q[DIV_DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_DVD_W-2:0], ge};
      rem_q <= ge ? DIV_DVS_W'(trial - {1'b0, dvs_q}) : trial[DIV_DVS_W-1:0];
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

[rtl/spectrum_decimate_colormap.sv]
// spectrum max-hold decimation with a nine-segment palette, top level
//
//  channel  direction  signals
//  in       sink       in_valid_i, in_ready_o, amplitude_i, frame_start_i
//  out      source     out_valid_o, out_ready_i, x_pos_o .. last_group_o
//  cfg      sink       cfg_we_i, cfg_idx_i, cfg_data_i
//
// a bin that closes no group leaves the sequencer idle and ready for the next bin;
// a bin that closes a group goes through accept, one multiply, then one to five
// divisions through the one shared bit-serial divider, then the output load.
// rst_ni returns the registers to their reset values and clears the counters and sequencer.
// a finished result waits in the output register while the next bin is taken;
// a second group result stalls the input until the first one is taken.
module spectrum_decimate_colormap #(
  parameter int unsigned MAX_BINS = sdc_pkg::MAX_BINS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [13:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [12:0] amplitude_i,
  input  logic               frame_start_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [16:0] x_pos_o,
  output logic signed [13:0] y_pos_o,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o,
  output logic [12:0]        group_index_o,
  output logic               last_group_o
);
  import sdc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_XDIV, S_YDIV, S_CDIV0, S_CDIV1, S_CDIV2, S_OUT
  } state_e;

  localparam logic [16:0] MAX_BINS_W = 17'(MAX_BINS);

  // registers
  logic [13:0]        bin_count_q;
  logic [2:0]         lod_q;
  logic [11:0]        fs_q;
  logic signed [12:0] clo_q, chi_q, pmin_q, pmax_q;

  state_e             state_q;
  logic               launched_q;
  logic [13:0]        bc_q, gc_q;
  logic signed [12:0] peak_q;
  logic signed [12:0] p_q;
  logic [13:0]        n_q, gidx_q;
  logic               last_q;
  logic signed [23:0] diff_q;
  logic signed [35:0] numx_q;
  logic [3:0]         cq_q;
  logic [12:0]        crem_q;
  logic signed [16:0] x_q;
  logic signed [13:0] y_q;
  logic [7:0]         r_q, g_q, b_q;

  logic               out_valid_q;
  logic signed [16:0] ox_q;
  logic signed [13:0] oy_q;
  logic [7:0]         or_q, og_q, ob_q;
  logic [12:0]        ogi_q;
  logic               olast_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  sdc_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // bin bookkeeping for the item at the input
  logic [13:0]        n_w, groups_w, used_w, mask_w, bc_e, gc_e, s_w, bc_nxt;
  logic [2:0]         sh_w;
  logic signed [12:0] peak_e, max_w, p_w;
  logic               drop_w, emit_w, accept;

  always_comb begin
    n_w = (17'(bin_count_q) > MAX_BINS_W) ? MAX_BINS_W[13:0] : bin_count_q;
    sh_w = (lod_q > 3'd4) ? 3'd4 : lod_q;
    if (lod_q == 3'd0) begin
      if (n_w > 14'd4000) sh_w = 3'd2;
      else if (n_w > 14'd2000) sh_w = 3'd1;
    end
    groups_w = n_w >> sh_w;
    used_w   = groups_w << sh_w;
    mask_w   = (14'd1 << sh_w) - 14'd1;
    bc_e     = frame_start_i ? 14'd0 : bc_q;
    gc_e     = frame_start_i ? 14'd0 : gc_q;
    peak_e   = frame_start_i ? PEAK_INIT : peak_q;
    max_w    = (amplitude_i > peak_e) ? amplitude_i : peak_e;
    drop_w   = bc_e >= used_w;
    emit_w   = !drop_w && ((bc_e & mask_w) == mask_w);
    bc_nxt   = (drop_w && bc_e >= n_w) ? bc_e : bc_e + 14'd1;
    p_w      = (max_w < PEAK_FLOOR) ? PEAK_SUBST : max_w;
    s_w      = gc_e << sh_w;
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // x operands
  logic [35:0] absx;
  assign absx = numx_q[35] ? 36'(-numx_q) : 36'(numx_q);

  // y operands
  logic signed [13:0] span_w, dp_w;
  logic signed [23:0] numy;
  logic [22:0]        absnum;
  logic [12:0]        absspan;
  logic               negy;
  always_comb begin
    span_w  = 14'(pmax_q) - 14'(pmin_q);
    dp_w    = 14'(p_q) - 14'(pmin_q);
    numy    = 24'(dp_w) * 24'sd640;
    absnum  = numy[23] ? 23'(-numy) : numy[22:0];
    absspan = span_w[13] ? 13'(-span_w) : span_w[12:0];
    negy    = numy[23] ^ span_w[13];
  end

  // palette operands
  logic signed [13:0] d_w, dd_w;
  logic [16:0]        t_w;
  logic [12:0]        du_w;
  logic               lo_hit, hi_hit;
  logic [35:0]        c_dvd;
  logic [19:0]        c_dvs;
  always_comb begin
    d_w    = 14'(p_q) - 14'(clo_q);
    dd_w   = 14'(chi_q) - 14'(clo_q);
    du_w   = dd_w[12:0];
    t_w    = 17'(d_w[12:0]) * 17'd9;
    lo_hit = p_q <= clo_q;
    hi_hit = p_q >= chi_q;
    unique case (cq_q)
      4'd0, 4'd1: begin
        c_dvd = 36'(t_w) * 36'd235;
        c_dvs = 20'(du_w) << 1;
      end
      4'd2, 4'd4, 4'd7: begin
        c_dvd = 36'(crem_q) * 36'd255;
        c_dvs = 20'(du_w);
      end
      4'd3: begin
        c_dvd = 36'(du_w - crem_q) * 36'd255;
        c_dvs = 20'(du_w);
      end
      4'd5: begin
        c_dvd = ((36'(du_w) << 1) - 36'(crem_q)) * 36'd255;
        c_dvs = 20'(du_w) << 1;
      end
      4'd6: begin
        c_dvd = 36'(du_w - crem_q) * 36'd255;
        c_dvs = 20'(du_w) << 1;
      end
      default: begin
        c_dvd = ((36'(du_w) << 2) - 36'(crem_q)) * 36'd255;
        c_dvs = 20'(du_w) << 2;
      end
    endcase
  end

  // divider request
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = 20'd1;
    unique case (state_q)
      S_XDIV: begin
        div_req.start    = !launched_q;
        div_req.dividend = 36'({absx[34:0], 1'b0}) + (36'(n_q) << 4);
        div_req.divisor  = 20'(n_q) << 5;
      end
      S_YDIV: begin
        div_req.start    = !launched_q && (span_w != 14'sd0);
        div_req.dividend = 36'({absnum, 1'b0}) + 36'(absspan);
        div_req.divisor  = 20'({absspan, 1'b0});
      end
      S_CDIV0: begin
        div_req.start    = !launched_q && !lo_hit && !hi_hit;
        div_req.dividend = 36'(t_w);
        div_req.divisor  = 20'(du_w);
      end
      S_CDIV1: begin
        div_req.start    = !launched_q;
        div_req.dividend = c_dvd;
        div_req.divisor  = c_dvs;
      end
      S_CDIV2: begin
        div_req.start    = !launched_q;
        div_req.dividend = 36'(crem_q) * 36'd255;
        div_req.divisor  = 20'(du_w) << 1;
      end
      default: ;
    endcase
  end

  logic [35:0] quo;
  assign quo = div_rsp.quotient;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_count_q <= BIN_COUNT_RST;
      lod_q       <= LOD_LEVEL_RST;
      fs_q        <= FREQ_SCALE_RST;
      clo_q       <= COLOR_LOWER_RST;
      chi_q       <= COLOR_UPPER_RST;
      pmin_q      <= PAN_MIN_RST;
      pmax_q      <= PAN_MAX_RST;
      state_q     <= S_IDLE;
      launched_q  <= 1'b0;
      bc_q        <= '0;
      gc_q        <= '0;
      peak_q      <= PEAK_INIT;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_BIN_COUNT:   bin_count_q <= cfg_data_i;
          REG_LOD_LEVEL:   lod_q       <= cfg_data_i[2:0];
          REG_FREQ_SCALE:  fs_q        <= cfg_data_i[11:0];
          REG_COLOR_LOWER: clo_q       <= cfg_data_i[12:0];
          REG_COLOR_UPPER: chi_q       <= cfg_data_i[12:0];
          REG_PAN_MIN:     pmin_q      <= cfg_data_i[12:0];
          REG_PAN_MAX:     pmax_q      <= cfg_data_i[12:0];
          default: ;
        endcase
      end

      // the output load in S_OUT owns the valid flag in its cycle
      if (out_valid_q && out_ready_i && state_q != S_OUT) out_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            bc_q <= bc_nxt;
            gc_q <= gc_e;
            if (drop_w) begin
              peak_q <= peak_e;
            end else if (!emit_w) begin
              peak_q <= max_w;
            end else begin
              peak_q  <= PEAK_INIT;
              gc_q    <= gc_e + 14'd1;
              p_q     <= p_w;
              n_q     <= n_w;
              gidx_q  <= gc_e;
              last_q  <= (gc_e + 14'd1) == groups_w;
              diff_q  <= $signed(24'(s_w) * 24'd400 - 24'(n_w) * 24'd200);
              state_q <= S_MUL;
            end
          end
        end
        S_MUL: begin
          numx_q  <= 36'($signed({1'b0, fs_q}) * diff_q);
          state_q <= S_XDIV;
        end
        S_XDIV: begin
          if (!launched_q) begin
            launched_q <= 1'b1;
          end else if (div_rsp.done) begin
            launched_q <= 1'b0;
            x_q        <= numx_q[35] ? 17'(17'd0 - quo[16:0]) : quo[16:0];
            state_q    <= S_YDIV;
          end
        end
        S_YDIV: begin
          if (!launched_q) begin
            if (span_w == 14'sd0) begin
              // flat pan range saturates on the side of the peak
              if (p_q > pmin_q) y_q <= 14'sd8191;
              else if (p_q < pmin_q) y_q <= 14'sh2000;
              else y_q <= 14'sd0;
              state_q <= S_CDIV0;
            end else begin
              launched_q <= 1'b1;
            end
          end else if (div_rsp.done) begin
            launched_q <= 1'b0;
            if (!negy) y_q <= (quo > 36'd8191) ? 14'sd8191 : quo[13:0];
            else y_q <= (quo > 36'd8192) ? 14'sh2000 : 14'(14'd0 - quo[13:0]);
            state_q <= S_CDIV0;
          end
        end
        S_CDIV0: begin
          if (!launched_q) begin
            if (lo_hit) begin
              r_q <= 8'd0; g_q <= 8'd0; b_q <= 8'd20;
              state_q <= S_OUT;
            end else if (hi_hit) begin
              r_q <= 8'd255; g_q <= 8'd255; b_q <= 8'd255;
              state_q <= S_OUT;
            end else begin
              launched_q <= 1'b1;
            end
          end else if (div_rsp.done) begin
            // segment number and position inside it
            launched_q <= 1'b0;
            cq_q       <= quo[3:0];
            crem_q     <= div_rsp.remainder[12:0];
            state_q    <= S_CDIV1;
          end
        end
        S_CDIV1: begin
          if (!launched_q) begin
            launched_q <= 1'b1;
          end else if (div_rsp.done) begin
            launched_q <= 1'b0;
            state_q    <= S_OUT;
            unique case (cq_q)
              4'd0, 4'd1: begin
                r_q <= 8'd0; g_q <= 8'd0; b_q <= 8'(8'd20 + quo[7:0]);
              end
              4'd2: begin r_q <= 8'd0; g_q <= quo[7:0]; b_q <= 8'd255; end
              4'd3: begin r_q <= 8'd0; g_q <= 8'd255; b_q <= quo[7:0]; end
              4'd4: begin r_q <= quo[7:0]; g_q <= 8'd255; b_q <= 8'd0; end
              4'd5, 4'd6: begin r_q <= 8'd255; g_q <= quo[7:0]; b_q <= 8'd0; end
              4'd7: begin r_q <= 8'd255; g_q <= 8'd0; b_q <= quo[7:0]; end
              default: begin
                r_q     <= quo[7:0];
                b_q     <= 8'd255;
                state_q <= S_CDIV2;
              end
            endcase
          end
        end
        S_CDIV2: begin
          if (!launched_q) begin
            launched_q <= 1'b1;
          end else if (div_rsp.done) begin
            launched_q <= 1'b0;
            g_q        <= quo[7:0];
            state_q    <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            ox_q        <= x_q;
            oy_q        <= y_q;
            or_q        <= r_q;
            og_q        <= g_q;
            ob_q        <= b_q;
            ogi_q       <= gidx_q[12:0];
            olast_q     <= last_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign x_pos_o       = ox_q;
  assign y_pos_o       = oy_q;
  assign red_o         = or_q;
  assign green_o       = og_q;
  assign blue_o        = ob_q;
  assign group_index_o = ogi_q;
  assign last_group_o  = olast_q;

endmodule
